### hw/rtl/assert_macros.svh
// Assertion helpers, clocked on the rising edge, muted while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/oge_pkg.sv
package oge_pkg;

    localparam int OGE_ELEMENTS = 4;

    localparam logic [31:0] OGE_ONE         = 32'd65536;
    localparam logic [16:0] OGE_ONE_K       = 17'd65536;
    localparam logic [16:0] OGE_MIN_GAIN    = 17'd66;
    localparam logic [31:0] OGE_RESET_VAR   = 32'd65536000;
    localparam logic [31:0] OGE_RESET_NOISE = 32'd655;

    localparam logic [5:0] OGE_GAIN_STEPS = 6'd17;
    localparam logic [5:0] OGE_FULL_STEPS = 6'd32;

    typedef enum logic [1:0] {
        CMD_UPDATE  = 2'd0,
        CMD_LOAD    = 2'd1,
        CMD_RESTART = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        REG_START_MVAR = 2'd0,
        REG_MEAN_NOISE = 2'd1,
        REG_START_SVAR = 2'd2,
        REG_SIGMA_NOISE = 2'd3
    } t_reg;

    // request to the shared divide / square-root unit
    typedef struct packed {
        logic        start;
        logic        sqrt;
        logic [32:0] rem0;
        logic [63:0] num;
        logic [32:0] den;
        logic [5:0]  steps;
    } t_du_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
    } t_du_rsp;

endpackage

### hw/rtl/oge_ram.sv
module oge_ram
    import oge_pkg::*;
#(
    parameter int WIDTH = 64,
    parameter int DEPTH = OGE_ELEMENTS,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/oge_divsqrt.sv
module oge_divsqrt
    import oge_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_du_req i_req,
    output t_du_rsp o_rsp
);
    logic [34:0] r_rem;
    logic [63:0] r_num;
    logic [31:0] r_q;
    logic [32:0] r_den;
    logic        r_sqrt;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [35:0] w_cand;
    logic [35:0] w_sub;
    logic [36:0] w_diff;
    logic        w_ge;

    // one compare/subtract per cycle: a quotient bit or a root bit
    always_comb begin
        w_cand = r_sqrt ? {r_rem[33:0], r_num[63:62]} : {r_rem, r_num[63]};
        w_sub  = r_sqrt ? {2'b00, r_q, 2'b01} : {3'b000, r_den};
        w_diff = {1'b0, w_cand} - {1'b0, w_sub};
        w_ge   = !w_diff[36];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= {2'b00, i_req.rem0};
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_sqrt <= i_req.sqrt;
                r_q    <= '0;
                r_cnt  <= i_req.steps;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[34:0] : w_cand[34:0];
                r_num <= r_sqrt ? {r_num[61:0], 2'b00} : {r_num[62:0], 1'b0};
                r_q   <= {r_q[30:0], w_ge};
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
endmodule

### hw/rtl/online_gaussian_estimator.sv
// Online Gaussian estimator: running mean and sigma per vector element, Q16.16.
// Input channel s_axis: one beat per element operation. tuser carries the
// command (update with sample, load mean and sigma, restart element).
// Output channel m_axis: exactly one beat per input beat, the element's
// mean and sigma after the operation (out-of-range index reports 0 / 1.0).
// Config port: i_cfg_we / i_cfg_index / i_cfg_data, write while idle.
// Timing: one beat at a time; s_axis_tready is high only when idle.
//   load, restart, unused command, bad index: the element is read and
//   decoded, and the result goes to the output register from S_DONE.
//   update: paced by the shared iterative divide/root unit (17 steps per
//   gain division; 32 steps for the square root).
//   update of the last element: also the two variance shrinks, a
//   32-step division each.
// Reset (synchronous, active low) restores the register defaults, both
// estimate variances to 1000.0, and marks every element as mean 0 /
// sigma 1.0 through per-element valid bits; no clearing pass.
// A stalled receiver holds the result in the output register; a new beat
// is still taken, and its result waits until the register frees up.
`include "assert_macros.svh"

module online_gaussian_estimator
    import oge_pkg::*;
#(
    parameter int ELEMENTS = OGE_ELEMENTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // element_index, sample_value, load_sigma, 2'b0
    input  logic [1:0]  s_axis_tuser,  // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // index_echo, new_mean, new_sigma, 2'b0
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int IW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
    localparam int VD = 2 ** IW;
    localparam logic [5:0] LAST_IDX = 6'(ELEMENTS - 1);
    localparam logic [6:0] NUM_EL   = 7'(ELEMENTS);

    typedef enum logic [4:0] {
        S_IDLE, S_READ, S_DEC, S_KM, S_MMUL, S_MADD, S_KS, S_SQA, S_SQB,
        S_BLA, S_BLB, S_BLC, S_ROOT0, S_ROOT, S_SHM, S_SHMD, S_SHMW,
        S_SHS, S_SHSD, S_SHSW, S_DONE
    } t_state;

    t_state r_state;

    // config
    logic [31:0] r_start_mvar, r_mnoise, r_start_svar, r_snoise;
    // scalar estimate variances
    logic [31:0] r_mvar, r_svar;

    // current item
    logic [1:0]  r_cmd;
    logic [5:0]  r_idx;
    logic [31:0] r_samp, r_lsig;

    // working registers
    logic [31:0] r_m, r_sig;
    logic [16:0] r_k;
    logic [64:0] r_prod;
    logic [47:0] r_a, r_b;
    logic [65:0] r_acc;
    logic        r_vld_rd;
    logic [VD-1:0] r_valid;

    // element store write port
    logic          r_we;
    logic [IW-1:0] r_waddr;
    logic [63:0]   r_wdata;
    logic [63:0]   w_rdata;

    // finished result, held until the output register is free
    logic [31:0] r_res_mean, r_res_sig;

    // result register
    logic        r_ovalid;
    logic [5:0]  r_oidx;
    logic [31:0] r_omean, r_osig;

    t_du_req r_req;
    t_du_rsp w_rsp;

    oge_ram #(.WIDTH(64), .DEPTH(ELEMENTS)) u_store (
        .i_clk   (i_clk),
        .i_we    (r_we),
        .i_waddr (r_waddr),
        .i_wdata (r_wdata),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (w_rdata)
    );

    oge_divsqrt u_du (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (w_rsp)
    );

    // datapath helpers
    logic [32:0] w_sm, w_ss;
    logic        w_neg;
    logic [32:0] w_d;
    logic [31:0] w_mag;
    logic [32:0] w_q;
    logic [33:0] w_nm;
    logic [31:0] w_nm_sat;
    logic [16:0] w_kq;
    logic [16:0] w_k;
    logic [31:0] w_sg;
    logic [31:0] w_cur_m, w_cur_s, w_lsig_f;
    logic        w_in_range;
    logic [47:0] w_m48_a;
    logic [16:0] w_m48_b;
    logic [31:0] w_m32_a, w_m32_b;
    logic [64:0] w_m48;
    logic [63:0] w_m32;

    always_comb begin
        w_sm  = {1'b0, r_mvar} + {1'b0, r_mnoise};
        w_ss  = {1'b0, r_svar} + {1'b0, r_snoise};
        w_neg = $signed(r_samp) < $signed(r_m);
        w_d   = {r_samp[31], r_samp} - {r_m[31], r_m};
        w_mag = w_neg ? 32'(-w_d) : w_d[31:0];
        // rounded step toward the sample
        w_q   = 33'((49'(r_prod[47:0]) + 49'd32768) >> 16);
        w_nm  = w_neg ? ({{2{r_m[31]}}, r_m} - {1'b0, w_q})
                      : ({{2{r_m[31]}}, r_m} + {1'b0, w_q});
        if ($signed(w_nm) > $signed(34'sh07FFFFFFF)) begin
            w_nm_sat = 32'h7FFFFFFF;
        end else if ($signed(w_nm) < -$signed(34'sh080000000)) begin
            w_nm_sat = 32'h80000000;
        end else begin
            w_nm_sat = w_nm[31:0];
        end
        w_kq = w_rsp.quot[16:0];
        w_k  = (w_kq < OGE_MIN_GAIN) ? OGE_MIN_GAIN : w_kq;
        w_sg = (w_rsp.quot < OGE_ONE) ? OGE_ONE : w_rsp.quot;
        w_cur_m  = r_vld_rd ? w_rdata[63:32] : 32'd0;
        w_cur_s  = r_vld_rd ? w_rdata[31:0] : OGE_ONE;
        w_lsig_f = (r_lsig < OGE_ONE) ? OGE_ONE : r_lsig;
        w_in_range = {1'b0, r_idx} < NUM_EL;

        // shared multipliers, operands by sequencer step
        unique case (r_state)
            S_BLA:   w_m48_a = r_a;
            S_BLB:   w_m48_a = r_b;
            default: w_m48_a = {16'd0, w_mag};
        endcase
        w_m48_b = (r_state == S_BLB) ? 17'(OGE_ONE_K - r_k) : r_k;
        unique case (r_state)
            S_SQB:   begin w_m32_a = r_sig;  w_m32_b = r_sig;    end
            S_SHM:   begin w_m32_a = r_mvar; w_m32_b = r_mnoise; end
            S_SHS:   begin w_m32_a = r_svar; w_m32_b = r_snoise; end
            default: begin w_m32_a = w_mag;  w_m32_b = w_mag;    end
        endcase
        w_m48 = 65'(w_m48_a) * 65'(w_m48_b);
        w_m32 = 64'(w_m32_a) * 64'(w_m32_b);
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_osig, r_omean, r_oidx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_start_mvar <= OGE_RESET_VAR;
            r_mnoise     <= OGE_RESET_NOISE;
            r_start_svar <= OGE_RESET_VAR;
            r_snoise     <= OGE_RESET_NOISE;
            r_mvar       <= OGE_RESET_VAR;
            r_svar       <= OGE_RESET_VAR;
            r_valid      <= '0;
            r_ovalid     <= 1'b0;
            r_we         <= 1'b0;
            r_req.start  <= 1'b0;
        end else begin
            r_we        <= 1'b0;
            r_req.start <= 1'b0;

            if (i_cfg_we) begin
                unique case (t_reg'(i_cfg_index))
                    REG_START_MVAR:  r_start_mvar <= i_cfg_data;
                    REG_MEAN_NOISE:  r_mnoise     <= i_cfg_data;
                    REG_START_SVAR:  r_start_svar <= i_cfg_data;
                    REG_SIGMA_NOISE: r_snoise     <= i_cfg_data;
                endcase
            end

            // S_DONE refills the register itself
            if (m_axis_tvalid && m_axis_tready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd   <= s_axis_tuser;
                        r_idx   <= s_axis_tdata[5:0];
                        r_samp  <= s_axis_tdata[37:6];
                        r_lsig  <= s_axis_tdata[69:38];
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_vld_rd <= r_valid[r_idx[IW-1:0]];
                    r_state  <= S_DEC;
                end
                S_DEC: begin
                    r_m     <= w_cur_m;
                    r_sig   <= w_cur_s;
                    r_waddr <= r_idx[IW-1:0];
                    if (!w_in_range) begin
                        r_res_mean <= 32'd0;
                        r_res_sig  <= OGE_ONE;
                        r_state    <= S_DONE;
                    end else begin
                        unique case (r_cmd)
                            CMD_UPDATE: begin
                                if (w_sm == 33'd0) begin
                                    r_k     <= OGE_MIN_GAIN;
                                    r_state <= S_MMUL;
                                end else begin
                                    r_req.start <= 1'b1;
                                    r_req.sqrt  <= 1'b0;
                                    r_req.rem0  <= {2'b00, r_mvar[31:1]};
                                    r_req.num   <= {r_mvar[0], 63'd0};
                                    r_req.den   <= w_sm;
                                    r_req.steps <= OGE_GAIN_STEPS;
                                    r_state     <= S_KM;
                                end
                            end
                            CMD_LOAD: begin
                                r_we       <= 1'b1;
                                r_wdata    <= {r_samp, w_lsig_f};
                                r_valid[r_idx[IW-1:0]] <= 1'b1;
                                r_res_mean <= r_samp;
                                r_res_sig  <= w_lsig_f;
                                r_state    <= S_DONE;
                            end
                            CMD_RESTART: begin
                                r_we       <= 1'b1;
                                r_wdata    <= {32'd0, OGE_ONE};
                                r_valid[r_idx[IW-1:0]] <= 1'b1;
                                r_res_mean <= 32'd0;
                                r_res_sig  <= OGE_ONE;
                                r_state    <= S_DONE;
                                if (r_idx == 6'd0) begin
                                    r_mvar <= r_start_mvar;
                                    r_svar <= r_start_svar;
                                end
                            end
                            default: begin  // unused command: report only
                                r_res_mean <= w_cur_m;
                                r_res_sig  <= w_cur_s;
                                r_state    <= S_DONE;
                            end
                        endcase
                    end
                end
                S_KM: begin
                    if (w_rsp.done) begin
                        r_k     <= w_k;
                        r_state <= S_MMUL;
                    end
                end
                S_MMUL: begin
                    r_prod  <= w_m48;
                    r_state <= S_MADD;
                end
                S_MADD: begin
                    r_m <= w_nm_sat;
                    if (w_ss == 33'd0) begin
                        r_k     <= OGE_MIN_GAIN;
                        r_state <= S_SQA;
                    end else begin
                        r_req.start <= 1'b1;
                        r_req.sqrt  <= 1'b0;
                        r_req.rem0  <= {2'b00, r_svar[31:1]};
                        r_req.num   <= {r_svar[0], 63'd0};
                        r_req.den   <= w_ss;
                        r_req.steps <= OGE_GAIN_STEPS;
                        r_state     <= S_KS;
                    end
                end
                S_KS: begin
                    if (w_rsp.done) begin
                        r_k     <= w_k;
                        r_state <= S_SQA;
                    end
                end
                S_SQA: begin
                    r_prod  <= {1'b0, w_m32};  // deviation squared
                    r_state <= S_SQB;
                end
                S_SQB: begin
                    r_a     <= r_prod[63:16];
                    r_prod  <= {1'b0, w_m32};  // old sigma squared
                    r_state <= S_BLA;
                end
                S_BLA: begin
                    r_b     <= r_prod[63:16];
                    r_prod  <= w_m48;
                    r_state <= S_BLB;
                end
                S_BLB: begin
                    r_acc   <= {1'b0, r_prod};
                    r_prod  <= w_m48;
                    r_state <= S_BLC;
                end
                S_BLC: begin
                    r_acc   <= r_acc + {1'b0, r_prod} + 66'd32768;
                    r_state <= S_ROOT0;
                end
                S_ROOT0: begin
                    r_req.start <= 1'b1;
                    r_req.sqrt  <= 1'b1;
                    r_req.rem0  <= '0;
                    r_req.num   <= {r_acc[63:16], 16'd0};
                    r_req.den   <= '0;
                    r_req.steps <= OGE_FULL_STEPS;
                    r_state     <= S_ROOT;
                end
                S_ROOT: begin
                    if (w_rsp.done) begin
                        r_we       <= 1'b1;
                        r_wdata    <= {r_m, w_sg};
                        r_valid[r_idx[IW-1:0]] <= 1'b1;
                        r_res_mean <= r_m;
                        r_res_sig  <= w_sg;
                        r_state    <= (r_idx == LAST_IDX) ? S_SHM : S_DONE;
                    end
                end
                S_SHM: begin
                    r_prod  <= {1'b0, w_m32};
                    r_state <= S_SHMD;
                end
                S_SHMD: begin
                    if (w_sm == 33'd0) begin
                        r_mvar  <= 32'd0;
                        r_state <= S_SHS;
                    end else begin
                        r_req.start <= 1'b1;
                        r_req.sqrt  <= 1'b0;
                        r_req.rem0  <= {1'b0, r_prod[63:32]};
                        r_req.num   <= {r_prod[31:0], 32'd0};
                        r_req.den   <= w_sm;
                        r_req.steps <= OGE_FULL_STEPS;
                        r_state     <= S_SHMW;
                    end
                end
                S_SHMW: begin
                    if (w_rsp.done) begin
                        r_mvar  <= w_rsp.quot;
                        r_state <= S_SHS;
                    end
                end
                S_SHS: begin
                    r_prod  <= {1'b0, w_m32};
                    r_state <= S_SHSD;
                end
                S_SHSD: begin
                    if (w_ss == 33'd0) begin
                        r_svar  <= 32'd0;
                        r_state <= S_DONE;
                    end else begin
                        r_req.start <= 1'b1;
                        r_req.sqrt  <= 1'b0;
                        r_req.rem0  <= {1'b0, r_prod[63:32]};
                        r_req.num   <= {r_prod[31:0], 32'd0};
                        r_req.den   <= w_ss;
                        r_req.steps <= OGE_FULL_STEPS;
                        r_state     <= S_SHSW;
                    end
                end
                S_SHSW: begin
                    if (w_rsp.done) begin
                        r_svar  <= w_rsp.quot;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hand over once the output register is free
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_oidx   <= r_idx;
                        r_omean  <= r_res_mean;
                        r_osig   <= r_res_sig;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // checks
    `ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready, !s_axis_tready, "beat taken while busy")
    `ASSERT_NOW(a_sigma_floor, i_clk, i_rst_n,
        m_axis_tvalid, m_axis_tdata[69:38] >= OGE_ONE, "sigma below 1.0")
    `ASSERT_NOW(a_du_done_expected, i_clk, i_rst_n,
        w_rsp.done, (r_state == S_KM) || (r_state == S_KS) || (r_state == S_ROOT) ||
        (r_state == S_SHMW) || (r_state == S_SHSW), "unit done with nobody waiting")
    `ASSERT_NOW(a_bad_index_mean, i_clk, i_rst_n,
        m_axis_tvalid && ({1'b0, m_axis_tdata[5:0]} >= NUM_EL),
        m_axis_tdata[37:6] == 32'd0, "out-of-range element reports a mean")
endmodule
